// File: rtl/sle_pkg.sv
// shared constants, types and opcodes of the sequential list engine
package sle_pkg;

	localparam int DEPTH  = 64;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int LEN_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int POS_W  = 7;
	localparam int POUT_W = 6;
	localparam int LOUT_W = 7;
	localparam int CMP_W  = (POS_W > LEN_W) ? POS_W : LEN_W;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [IDX_W-1:0]         idx_t;
	typedef logic [LEN_W-1:0]         len_t;
	typedef logic [POS_W-1:0]         pos_t;
	typedef logic [POUT_W-1:0]        pout_t;
	typedef logic [LOUT_W-1:0]        lout_t;
	typedef logic [CMP_W-1:0]         cmp_t;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_DELMIN = 2'd3
	} op_t;

	// broadcast to every cell during a sweep
	typedef struct packed {
		op_t   op;
		data_t target;
		cmp_t  pos;
		len_t  count;
	} cmd_t;

	// broadcast list update, applied by every cell in the same cycle
	typedef struct packed {
		logic  shift_up;
		logic  shift_down;
		logic  move;
		cmp_t  pos;
		idx_t  at;
		data_t wdata;
	} upd_t;

	// partial result handed from cell to cell
	typedef struct packed {
		logic  found;
		idx_t  idx;
		data_t best;
		data_t last;
	} carry_t;

endpackage

// File: rtl/sle_in_if.sv
// channel interfaces for command and result transactions
interface sle_in_if;
	logic                 valid;
	logic                 ready;
	sle_pkg::op_t         opcode;
	sle_pkg::pos_t        position_in;
	sle_pkg::data_t       value_in;

	modport source (output valid, output opcode, output position_in, output value_in,
		input ready);
	modport sink (input valid, input opcode, input position_in, input value_in,
		output ready);
endinterface

interface sle_out_if;
	logic                 valid;
	logic                 ready;
	logic                 ok;
	sle_pkg::pout_t       position_out;
	sle_pkg::data_t       removed_value;
	sle_pkg::lout_t       list_length;

	modport source (output valid, output ok, output position_out, output removed_value,
		output list_length, input ready);
	modport sink (input valid, input ok, input position_out, input removed_value,
		input list_length, output ready);
endinterface

// File: rtl/sle_cell.sv
// one list entry with its local match, select and minimum step
module sle_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  sle_pkg::idx_t    index,
	input  sle_pkg::cmd_t    cmd,
	input  sle_pkg::upd_t    upd,
	input  sle_pkg::data_t   left_val,
	input  sle_pkg::data_t   right_val,
	input  sle_pkg::carry_t  carry_in,
	output sle_pkg::data_t   val,
	output sle_pkg::carry_t  carry_out
);

	sle_pkg::data_t  val_q;
	sle_pkg::carry_t carry_q;
	sle_pkg::carry_t carry_d;
	sle_pkg::cmp_t   here;
	logic            active;

	assign here   = sle_pkg::cmp_t'(index);
	assign active = here < sle_pkg::cmp_t'(cmd.count);

	always_ff @(posedge clk) begin
		if (upd.shift_up && here > upd.pos) begin
			val_q <= left_val;
		end else if (upd.shift_up && here == upd.pos) begin
			val_q <= upd.wdata;
		end else if (upd.shift_down && here >= upd.pos) begin
			val_q <= right_val;
		end else if (upd.move && index == upd.at) begin
			val_q <= upd.wdata;
		end
	end

	always_comb begin
		carry_d = carry_in;
		if (active) begin
			carry_d.last = val_q;
			case (cmd.op)
				sle_pkg::OP_LOCATE: begin
					if (!carry_in.found && val_q == cmd.target) begin
						carry_d.found = 1'b1;
						carry_d.idx   = index;
					end
				end
				sle_pkg::OP_DELETE: begin
					if (here == cmd.pos) begin
						carry_d.found = 1'b1;
						carry_d.idx   = index;
						carry_d.best  = val_q;
					end
				end
				sle_pkg::OP_DELMIN: begin
					if (!carry_in.found || val_q < carry_in.best) begin
						carry_d.found = 1'b1;
						carry_d.idx   = index;
						carry_d.best  = val_q;
					end
				end
				default: begin
					carry_d = carry_in;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	assign val       = val_q;
	assign carry_out = carry_q;

endmodule

// File: rtl/sequential_list_engine.sv
// top level of the sequential list engine: control, cell chain and result register
// The list lives in a chain of DEPTH cells, one signed word each, and starts empty
// after reset. An insert shifts the whole chain at once; its result is registered
// and then moved to the output register once that is free. Delete, locate and
// delete-min send a wave through the chain, one cell a cycle, and their result is
// registered once the wave has reached the last cell. One command is worked on at a
// time; a new one is taken while the previous result still waits in the output
// register.
module sequential_list_engine (
	input logic        clk,
	input logic        arst_n,
	sle_in_if.sink     in_ch,
	sle_out_if.source  out_ch
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SWEEP = 3'b010,
		S_FIN   = 3'b100
	} state_t;

	typedef struct packed {
		logic           ok;
		sle_pkg::pout_t pout;
		sle_pkg::data_t removed;
		sle_pkg::lout_t len;
	} res_t;

	state_t          state_q;
	sle_pkg::op_t    op_q;
	sle_pkg::cmp_t   pos_q;
	sle_pkg::data_t  val_q;
	sle_pkg::len_t   count_q;
	sle_pkg::len_t   step_q;
	res_t            res_q;
	res_t            res_d;
	res_t            out_q;
	logic            out_valid_q;

	sle_pkg::cmd_t   cmd;
	sle_pkg::upd_t   upd;
	sle_pkg::data_t  vals  [sle_pkg::DEPTH];
	sle_pkg::carry_t carry [sle_pkg::DEPTH];
	sle_pkg::carry_t fin;

	sle_pkg::cmp_t   in_pos;
	logic            in_acc;
	logic            ins_ok;
	logic            del_ok;
	logic            sweep_done;
	logic            out_load;
	sle_pkg::len_t   count_d;

	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign in_pos      = sle_pkg::cmp_t'(in_ch.position_in);
	assign ins_ok      = (in_pos <= sle_pkg::cmp_t'(count_q)) &&
		(count_q < sle_pkg::len_t'(sle_pkg::DEPTH));
	assign del_ok      = pos_q < sle_pkg::cmp_t'(count_q);
	assign sweep_done  = (state_q == S_SWEEP) && (step_q == sle_pkg::len_t'(sle_pkg::DEPTH));
	assign fin         = carry[sle_pkg::DEPTH-1];
	assign out_load    = (state_q == S_FIN) && (!out_valid_q || out_ch.ready);

	assign cmd.op     = op_q;
	assign cmd.target = val_q;
	assign cmd.pos    = pos_q;
	assign cmd.count  = count_q;

	// list update and result
	always_comb begin
		upd     = '0;
		res_d   = '0;
		count_d = count_q;
		if (in_acc && in_ch.opcode == sle_pkg::OP_INSERT) begin
			if (ins_ok) begin
				upd.shift_up = 1'b1;
				upd.pos      = in_pos;
				upd.wdata    = in_ch.value_in;
				count_d      = count_q + sle_pkg::len_t'(1);
			end
			res_d.ok  = ins_ok;
			res_d.len = sle_pkg::lout_t'(count_d);
		end else if (sweep_done) begin
			case (op_q)
				sle_pkg::OP_DELETE: begin
					if (del_ok) begin
						upd.shift_down = 1'b1;
						upd.pos        = pos_q;
						count_d        = count_q - sle_pkg::len_t'(1);
						res_d.removed  = fin.best;
					end
					res_d.ok = del_ok;
				end
				sle_pkg::OP_LOCATE: begin
					res_d.ok = fin.found;
					if (fin.found) begin
						res_d.pout = sle_pkg::pout_t'(fin.idx);
					end
				end
				sle_pkg::OP_DELMIN: begin
					if (fin.found) begin
						upd.move      = 1'b1;
						upd.at        = fin.idx;
						upd.wdata     = fin.last;
						count_d       = count_q - sle_pkg::len_t'(1);
						res_d.pout    = sle_pkg::pout_t'(fin.idx);
						res_d.removed = fin.best;
					end
					res_d.ok = fin.found;
				end
				default: begin
					res_d.ok = 1'b0;
				end
			endcase
			res_d.len = sle_pkg::lout_t'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						step_q  <= '0;
						state_q <= (in_ch.opcode == sle_pkg::OP_INSERT) ? S_FIN : S_SWEEP;
					end
				end
				S_SWEEP: begin
					step_q <= step_q + sle_pkg::len_t'(1);
					if (sweep_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q  <= in_ch.opcode;
			pos_q <= in_pos;
			val_q <= in_ch.value_in;
		end
		if ((in_acc && in_ch.opcode == sle_pkg::OP_INSERT) || sweep_done) begin
			res_q <= res_d;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	// cell chain
	for (genvar g = 0; g < sle_pkg::DEPTH; g++) begin : g_cell
		sle_pkg::data_t  left_val;
		sle_pkg::data_t  right_val;
		sle_pkg::carry_t carry_in;

		if (g == 0) begin : g_first
			assign left_val = '0;
			assign carry_in = '0;
		end else begin : g_inner
			assign left_val = vals[g-1];
			assign carry_in = carry[g-1];
		end

		if (g == sle_pkg::DEPTH - 1) begin : g_last
			assign right_val = '0;
		end else begin : g_body
			assign right_val = vals[g+1];
		end

		sle_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.index     (sle_pkg::idx_t'(g)),
			.cmd       (cmd),
			.upd       (upd),
			.left_val  (left_val),
			.right_val (right_val),
			.carry_in  (carry_in),
			.val       (vals[g]),
			.carry_out (carry[g])
		);
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.ok            = out_q.ok;
	assign out_ch.position_out  = out_q.pout;
	assign out_ch.removed_value = out_q.removed;
	assign out_ch.list_length   = out_q.len;

endmodule

// File: rtl/sle_checker.sv
// port-level checks of the sequential list engine and their binding
module sle_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input logic           ok,
	input sle_pkg::pout_t position_out,
	input sle_pkg::data_t removed_value,
	input sle_pkg::lout_t list_length
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(position_out) &&
		$stable(removed_value) && $stable(list_length))
		else $error("result changed while stalled");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> list_length <= sle_pkg::lout_t'(sle_pkg::DEPTH))
		else $error("list length beyond depth");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> position_out == '0 && removed_value == '0)
		else $error("failed result carries data");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.ok            (out_ch.ok),
	.position_out  (out_ch.position_out),
	.removed_value (out_ch.removed_value),
	.list_length   (out_ch.list_length)
);
